// File: hdl/tdm_pkg.sv
// Shared constants and types for the TEA Davies-Meyer hash block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tdm_pkg;

  localparam int WORD_W       = 32;
  localparam int BC_W         = 17;
  localparam int IDX_W        = 16;
  localparam int BLOCK_ROUNDS = 6;
  localparam int FINAL_ROUNDS = 10;

  localparam logic [WORD_W-1:0] TEA_DELTA       = 32'h9E3779B9;
  localparam logic [WORD_W-1:0] CHAIN_LOW_INIT  = 32'h9464a485;
  localparam logic [WORD_W-1:0] CHAIN_HIGH_INIT = 32'h542e1a94;
  localparam logic [BC_W-1:0]   BUCKET_RESET    = 17'd1024;
  localparam logic [BC_W-1:0]   BUCKET_MAX      = 17'h10000;

  localparam logic [2:0]        REG_BUCKET      = 3'd0;

  typedef logic [WORD_W-1:0] word_t;

endpackage

// File: hdl/tea_davies_meyer_hash.sv
// Key bytes enter one beat per cycle while the block is idle (tuser flags a byte, tlast
// ends the key) and are buffered until 16 are held. A beat that completes a block holds the
// input for one load, 12 half rounds through the single shared TEA unit and one feed-forward
// add. The tlast beat holds it for 20 half rounds for the final block, the fold, and the
// one-bit-per-cycle remainder unit that forms the bucket index. A tlast beat that also
// completes a block runs the block pass first. The result sits in an output register, so
// the next key may start while it waits to be taken. bucket_count lives at address 0 of
// the APB port.
// Depends on tdm_pkg, tdm_round and tdm_mod.
`timescale 1ns / 1ps

module tea_davies_meyer_hash
  import tdm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] hash_value, [47:32] bucket_index
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MIX  = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_DIVS = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam int          HALF_W     = $clog2(2 * FINAL_ROUNDS);
  localparam logic [HALF_W-1:0] BLOCK_LAST = HALF_W'(2 * BLOCK_ROUNDS - 1);
  localparam logic [HALF_W-1:0] FINAL_LAST = HALF_W'(2 * FINAL_ROUNDS - 1);

  logic [2:0]        state_q, state_d;
  logic [BC_W-1:0]   bc_q;
  word_t             cl_q, ch_q, b0_q, b1_q, sum_q, len_q, hash_q;
  word_t             w_q [4];
  word_t             w_fin [4];
  logic [3:0][3:0][7:0] blk_q;
  logic              blk_pend_q, fin_pend_q, fin_q;
  logic [HALF_W-1:0] cnt_q;
  logic              m_valid_q;
  word_t             m_hash_q;
  logic [IDX_W-1:0]  m_idx_q;

  logic              in_fire, cfg_wr, out_load, half_last;
  word_t             rnd_x, rnd_y, rnd_ka, rnd_kb, rnd_out;
  word_t             pad_w, pad_p, tail_w, tail_src;
  logic [1:0]        nwords, nextra;
  logic [BC_W-1:0]   divisor;
  logic              div_done;
  logic [IDX_W-1:0]  div_rem;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign pready        = 1'b1;
  assign prdata        = (paddr == REG_BUCKET) ? {{(32 - BC_W){1'b0}}, bc_q} : '0;
  assign out_load      = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);
  assign half_last     = (cnt_q == (fin_q ? FINAL_LAST : BLOCK_LAST));
  assign divisor       = bc_q[BC_W-1] ? BUCKET_MAX : bc_q;

  // final block: whole words, then pad words with leftover bytes shifted into the first
  assign nwords   = len_q[3:2];
  assign nextra   = len_q[1:0];
  assign pad_p    = len_q | (len_q << 8);
  assign pad_w    = pad_p | (pad_p << 16);
  assign tail_src = blk_q[nwords];

  always_comb begin
    tail_w = pad_w;
    if (nextra >= 2'd1) tail_w = (tail_w << 8) | {{24{tail_src[7]}}, tail_src[7:0]};
    if (nextra >= 2'd2) tail_w = (tail_w << 8) | {{24{tail_src[15]}}, tail_src[15:8]};
    if (nextra == 2'd3) tail_w = (tail_w << 8) | {{24{tail_src[23]}}, tail_src[23:16]};
    for (int j = 0; j < 4; j++) begin
      if (2'(j) < nwords) begin
        w_fin[j] = blk_q[j];
      end else if (2'(j) == nwords) begin
        w_fin[j] = tail_w;
      end else begin
        w_fin[j] = pad_w;
      end
    end
  end

  // shared half-round operands
  always_comb begin
    if (!cnt_q[0]) begin
      rnd_x  = b0_q;
      rnd_y  = b1_q;
      rnd_ka = w_q[0];
      rnd_kb = w_q[1];
    end else begin
      rnd_x  = b1_q;
      rnd_y  = b0_q;
      rnd_ka = w_q[2];
      rnd_kb = w_q[3];
    end
  end

  tdm_round u_round (
    .x_i   (rnd_x),
    .y_i   (rnd_y),
    .ka_i  (rnd_ka),
    .kb_i  (rnd_kb),
    .sum_i (sum_q),
    .x_o   (rnd_out)
  );

  tdm_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DIVS),
    .dividend_i (cl_q ^ ch_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire && ((s_axis_tuser && len_q[3:0] == 4'hF) || s_axis_tlast)) begin
        state_d = S_LOAD;
      end
      S_LOAD: state_d = S_MIX;
      S_MIX:  if (half_last) state_d = S_FOLD;
      S_FOLD: begin
        if (fin_q) state_d = S_DIVS;
        else if (fin_pend_q) state_d = S_LOAD;
        else state_d = S_IDLE;
      end
      S_DIVS: state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      bc_q       <= BUCKET_RESET;
      cl_q       <= CHAIN_LOW_INIT;
      ch_q       <= CHAIN_HIGH_INIT;
      len_q      <= '0;
      blk_pend_q <= 1'b0;
      fin_pend_q <= 1'b0;
      fin_q      <= 1'b0;
      cnt_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr && paddr == REG_BUCKET) bc_q <= pwdata[BC_W-1:0];
      if (in_fire) begin
        if (s_axis_tuser) len_q <= len_q + 1'b1;
        blk_pend_q <= s_axis_tuser && (len_q[3:0] == 4'hF);
        fin_pend_q <= s_axis_tlast;
      end
      if (state_q == S_LOAD) begin
        fin_q <= !blk_pend_q;
        cnt_q <= '0;
      end
      if (state_q == S_MIX) cnt_q <= cnt_q + 1'b1;
      if (state_q == S_FOLD) begin
        cl_q <= cl_q + b0_q;
        ch_q <= ch_q + b1_q;
        if (!fin_q) blk_pend_q <= 1'b0;
      end
      if (out_load) begin
        cl_q       <= CHAIN_LOW_INIT;
        ch_q       <= CHAIN_HIGH_INIT;
        len_q      <= '0;
        fin_pend_q <= 1'b0;
        m_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tuser) blk_q[len_q[3:2]][len_q[1:0]] <= s_axis_tdata;
    if (state_q == S_LOAD) begin
      for (int j = 0; j < 4; j++) begin
        w_q[j] <= blk_pend_q ? blk_q[j] : w_fin[j];
      end
      b0_q  <= cl_q;
      b1_q  <= ch_q;
      sum_q <= TEA_DELTA;
    end
    if (state_q == S_MIX) begin
      if (!cnt_q[0]) begin
        b0_q <= rnd_out;
      end else begin
        b1_q  <= rnd_out;
        sum_q <= sum_q + TEA_DELTA;
      end
    end
    if (state_q == S_DIVS) hash_q <= cl_q ^ ch_q;
    if (out_load) begin
      m_hash_q <= hash_q;
      m_idx_q  <= (divisor == '0) ? '0 : div_rem;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_idx_q, m_hash_q};

  a_mix_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MIX) |-> (cnt_q <= (fin_q ? FINAL_LAST : BLOCK_LAST)))
    else $error("half-round count past the round limit");

  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (len_q == $past(len_q) + {31'b0, $past(s_axis_tuser)}))
    else $error("key length did not track the byte beat");

  a_block_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FOLD && !fin_q) |-> (len_q[3:0] == 4'h0))
    else $error("block mix folded without a full block");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("remainder finished outside the wait state");

endmodule

// File: hdl/tdm_round.sv
// One TEA half round: the shared mixing unit of the block.
// Depends on tdm_pkg.
`timescale 1ns / 1ps

module tdm_round
  import tdm_pkg::*;
(
  input  word_t x_i,
  input  word_t y_i,
  input  word_t ka_i,
  input  word_t kb_i,
  input  word_t sum_i,
  output word_t x_o
);

  word_t mix;

  assign mix = ((y_i << 4) + ka_i) ^ (y_i + sum_i) ^ ((y_i >> 5) + kb_i);
  assign x_o = x_i + mix;

endmodule

// File: hdl/tdm_mod.sv
// Restoring remainder unit, one dividend bit per cycle.
// Depends on tdm_pkg.
`timescale 1ns / 1ps

module tdm_mod
  import tdm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  word_t            dividend_i,
  input  logic [BC_W-1:0]  divisor_i,
  output logic             done_o,
  output logic [IDX_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(WORD_W);

  word_t             quo_q;
  logic [BC_W-1:0]   rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [BC_W:0]     rem_sh;
  logic [BC_W-1:0]   rem_d;

  assign rem_sh = {rem_q, quo_q[WORD_W-1]};

  always_comb begin
    if (rem_sh >= {1'b0, divisor_i}) begin
      rem_d = BC_W'(rem_sh - {1'b0, divisor_i});
    end else begin
      rem_d = rem_sh[BC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(WORD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_q << 1;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[IDX_W-1:0];

endmodule
